FILE: rtl/core/bdc_pkg.sv
// Shared types and constants of the byte compare block.
package bdc_pkg;

  // What one queued entry asks the back end to emit.
  typedef enum logic [2:0] {
    EV_TOTAL,
    EV_DIFF,
    EV_PATCH,
    EV_CTX,
    EV_OPEN
  } ev_t;

  // record_kind codes on the result channel
  localparam logic [2:0] KIND_SEP   = 3'd0;
  localparam logic [2:0] KIND_CTX   = 3'd1;
  localparam logic [2:0] KIND_DIFF  = 3'd2;
  localparam logic [2:0] KIND_PATCH = 3'd3;
  localparam logic [2:0] KIND_TOTAL = 3'd4;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_PATCH_MODE = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNT_ONLY = 1'd1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    ev_t         ev;
    logic [7:0]  bo;
    logic [7:0]  bn;
    logic [31:0] total;
  } desc_t;

  typedef struct packed {
    logic patch_mode;
    logic count_only;
  } mode_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

endpackage

FILE: rtl/core/bdc_front.sv
// Front end: compare byte pairs, keep the context state, queue emit requests.
module bdc_front import bdc_pkg::*; #(
  parameter int CONTEXT_BYTES = 3,
  parameter int OFFSET_BITS   = 32,
  parameter int FW            = $clog2(CONTEXT_BYTES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mode_t                      mode,
  input  logic                       accept,
  input  logic [7:0]                 byte_old,
  input  logic [7:0]                 byte_new,
  input  logic                       end_of_data,
  output logic                       push,
  output desc_t                      desc,
  output logic [OFFSET_BITS-1:0]     pos,
  output logic [FW-1:0]              fill,
  output logic [CONTEXT_BYTES*8-1:0] ring_flat
);

  logic [7:0]             ring_r [CONTEXT_BYTES];
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [FW-1:0]          trail_r, trail_nxt;
  logic                   in_hunk_r, in_hunk_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]            cnt_r, cnt_nxt;
  logic                   shift_in;
  logic                   full_mode;
  logic                   mismatch;

  assign full_mode = !mode.count_only && !mode.patch_mode;
  assign mismatch  = byte_old != byte_new;

  always_comb begin
    fill_nxt    = fill_r;
    trail_nxt   = trail_r;
    in_hunk_nxt = in_hunk_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    shift_in    = 1'b0;
    push        = 1'b0;
    desc.ev     = EV_TOTAL;
    desc.bo     = byte_old;
    desc.bn     = byte_new;
    if (accept) begin
      if (end_of_data) begin
        push        = 1'b1;
        desc.ev     = EV_TOTAL;
        fill_nxt    = '0;
        trail_nxt   = '0;
        in_hunk_nxt = 1'b0;
        pos_nxt     = '0;
        cnt_nxt     = '0;
      end else begin
        pos_nxt = pos_r + OFFSET_BITS'(1);
        if (mismatch) begin
          if (cnt_r != 32'hFFFF_FFFF) begin
            cnt_nxt = cnt_r + 32'd1;
          end
          push = !mode.count_only;
          if (full_mode && !in_hunk_r) begin
            desc.ev = EV_OPEN;
          end else if (full_mode) begin
            desc.ev = EV_DIFF;
          end else begin
            desc.ev = EV_PATCH;
          end
          in_hunk_nxt = 1'b1;
          trail_nxt   = FW'(CONTEXT_BYTES);
        end else begin
          shift_in = 1'b1;
          if (fill_r < FW'(CONTEXT_BYTES)) begin
            fill_nxt = fill_r + FW'(1);
          end
          if (trail_r != '0) begin
            push      = full_mode;
            desc.ev   = EV_CTX;
            trail_nxt = trail_r - FW'(1);
          end else begin
            in_hunk_nxt = 1'b0;
          end
        end
      end
    end
    // total as seen by this item's records; the end item reports the old count
    desc.total = (accept && end_of_data) ? cnt_r : cnt_nxt;
  end

  assign pos  = pos_r;
  assign fill = fill_r;

  for (genvar i = 0; i < CONTEXT_BYTES; i++) begin : g_ring
    assign ring_flat[i*8 +: 8] = ring_r[i];
  end

  // newest byte in slot 0; the shift line carries no reset need beyond fill
  always_ff @(posedge clk) begin
    if (shift_in) begin
      ring_r[0] <= byte_old;
      for (int i = 1; i < CONTEXT_BYTES; i++) begin
        ring_r[i] <= ring_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      trail_r   <= '0;
      in_hunk_r <= 1'b0;
      pos_r     <= '0;
      cnt_r     <= '0;
    end else begin
      fill_r    <= fill_nxt;
      trail_r   <= trail_nxt;
      in_hunk_r <= in_hunk_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/bdc_queue.sv
// Short queue of emit requests between front and back end.
module bdc_queue import bdc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output qstat_t       stat
);

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign rd_data        = mem_r[rd_ptr_r];
  assign stat.not_empty = cnt_r != '0;
  assign stat.full      = cnt_r == (QPTR_W + 1)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.not_empty)
    else $error("queue read while empty");

endmodule

FILE: rtl/core/bdc_back.sv
// Back end: expand queued requests into result words, one per cycle unless out_tready stalls the output.
module bdc_back import bdc_pkg::*; #(
  parameter int CONTEXT_BYTES = 3,
  parameter int OFFSET_BITS   = 32,
  parameter int FW            = $clog2(CONTEXT_BYTES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qstat_t                     qstat,
  input  desc_t                      desc,
  input  logic [OFFSET_BITS-1:0]     pos,
  input  logic [FW-1:0]              fill,
  input  logic [CONTEXT_BYTES*8-1:0] ring_flat,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [79:0]                out_tdata,
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast
);

  localparam int SPW = $clog2(CONTEXT_BYTES + 2);
  localparam int RIW = (CONTEXT_BYTES > 1) ? $clog2(CONTEXT_BYTES) : 1;

  logic [7:0]             ring_a [CONTEXT_BYTES];
  logic [SPW-1:0]         step_r, step_nxt;
  logic                   valid_r, valid_nxt;
  logic [2:0]             kind_r, kind_c;
  logic [79:0]            data_r;
  logic                   last_r, last_c;
  logic [31:0]            off_c, pos32, ctx32;
  logic [7:0]             vo_c, vn_c;
  logic [FW-1:0]          idx;
  logic [OFFSET_BITS-1:0] ctx_off;
  logic [SPW-1:0]         last_step;
  logic                   load;

  for (genvar i = 0; i < CONTEXT_BYTES; i++) begin : g_unpack
    assign ring_a[i] = ring_flat[i*8 +: 8];
  end

  // context records walk the ring oldest first: slot fill-step
  assign idx     = fill - step_r[FW-1:0];
  assign ctx_off = pos - OFFSET_BITS'(idx) - OFFSET_BITS'(1);

  if (OFFSET_BITS >= 32) begin : g_wide
    assign pos32 = pos[31:0];
    assign ctx32 = ctx_off[31:0];
  end else begin : g_narrow
    assign pos32 = {{(32 - OFFSET_BITS){1'b0}}, pos};
    assign ctx32 = {{(32 - OFFSET_BITS){1'b0}}, ctx_off};
  end

  assign last_step = (desc.ev == EV_OPEN) ? SPW'(fill) + SPW'(1) : '0;
  assign last_c    = step_r == last_step;
  assign load      = qstat.not_empty && (!valid_r || out_tready);
  assign pop       = load && last_c;

  always_comb begin
    kind_c = KIND_TOTAL;
    off_c  = '0;
    vo_c   = '0;
    vn_c   = '0;
    case (desc.ev)
      EV_TOTAL: begin
        kind_c = KIND_TOTAL;
      end
      EV_DIFF: begin
        kind_c = KIND_DIFF;
        off_c  = pos32;
        vo_c   = desc.bo;
        vn_c   = desc.bn;
      end
      EV_PATCH: begin
        kind_c = KIND_PATCH;
        off_c  = pos32;
        vn_c   = desc.bn;
      end
      EV_CTX: begin
        kind_c = KIND_CTX;
        off_c  = pos32;
        vo_c   = desc.bo;
      end
      EV_OPEN: begin
        if (step_r == '0) begin
          kind_c = KIND_SEP;
        end else if (last_c) begin
          kind_c = KIND_DIFF;
          off_c  = pos32;
          vo_c   = desc.bo;
          vn_c   = desc.bn;
        end else begin
          kind_c = KIND_CTX;
          off_c  = ctx32;
          vo_c   = ring_a[idx[RIW-1:0]];
        end
      end
      default: begin
        kind_c = KIND_TOTAL;
      end
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = last_c ? '0 : step_r + SPW'(1);
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_c;
      data_r <= {desc.total, vn_c, vo_c, off_c};
      last_r <= last_c;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= SPW'(CONTEXT_BYTES + 1))
    else $error("sequencer step out of range");

  a_total_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_TOTAL) |-> out_tlast)
    else $error("total word without tlast");

  a_sep_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_SEP) |-> !out_tlast)
    else $error("separator closed an item");

endmodule

FILE: rtl/core/byte_diff_with_context_core.sv
// Top level of the byte compare block with context output.
//
//  port group | dir | tdata fields (low bit up)                   | tuser       | tlast
//  in_*       | in  | byte_old[7:0], byte_new[15:8]               | -           | end_of_data
//  out_*      | out | offset[31:0], value_old[39:32],              | record_kind | last
//             |     | value_new[47:40], mismatch_total[79:48]     |             |
//  cfg_*      | in  | cfg_addr 0 patch_mode, 1 count_only; cfg_wdata bit 0
//
// One byte pair is taken per cycle while the request queue has room; the
// front end updates its state and queues at most one request per pair.
// The back end drains one result word per cycle while out_tready is high; a pair
// that opens a hunk expands into fill+2 words (up to CONTEXT_BYTES+2).
// Reset (rst_n low, synchronous) clears the state, the queue and the modes.
// A stall on out_tready holds the output register; the queue keeps taking
// pairs until it holds QDEPTH requests, then in_tready drops.
module byte_diff_with_context_core import bdc_pkg::*; #(
  parameter int CONTEXT_BYTES = 3,
  parameter int OFFSET_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // byte_old, byte_new
  input  logic                  in_tlast,   // end_of_data
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [79:0]           out_tdata,  // offset, value_old, value_new, mismatch_total
  output logic [2:0]            out_tuser,  // record_kind
  output logic                  out_tlast,  // last
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic                  cfg_wdata
);

  localparam int FW = $clog2(CONTEXT_BYTES + 1);
  localparam int QW = $bits(desc_t) + OFFSET_BITS + FW + CONTEXT_BYTES * 8;

  mode_t                      mode_r;
  logic                       accept;
  logic                       push;
  desc_t                      f_desc, b_desc;
  logic [OFFSET_BITS-1:0]     f_pos, b_pos;
  logic [FW-1:0]              f_fill, b_fill;
  logic [CONTEXT_BYTES*8-1:0] f_ring, b_ring;
  logic [QW-1:0]              q_wr, q_rd;
  logic                       pop;
  qstat_t                     qstat;

  // mode registers; writes must arrive only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATCH_MODE: mode_r.patch_mode <= cfg_wdata;
        REG_COUNT_ONLY: mode_r.count_only <= cfg_wdata;
        default:        mode_r            <= mode_r;
      endcase
    end
  end

  // take a pair whenever the queue can hold its request
  assign in_tready = !qstat.full;
  assign accept    = in_tvalid && in_tready;

  bdc_front #(
    .CONTEXT_BYTES(CONTEXT_BYTES),
    .OFFSET_BITS  (OFFSET_BITS),
    .FW           (FW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .accept     (accept),
    .byte_old   (in_tdata[7:0]),
    .byte_new   (in_tdata[15:8]),
    .end_of_data(in_tlast),
    .push       (push),
    .desc       (f_desc),
    .pos        (f_pos),
    .fill       (f_fill),
    .ring_flat  (f_ring)
  );

  // each request carries a snapshot of position and ring for the back end
  assign q_wr = {f_pos, f_fill, f_ring, f_desc};
  assign {b_pos, b_fill, b_ring, b_desc} = q_rd;

  bdc_queue #(
    .W(QW)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_data(q_wr),
    .pop    (pop),
    .rd_data(q_rd),
    .stat   (qstat)
  );

  bdc_back #(
    .CONTEXT_BYTES(CONTEXT_BYTES),
    .OFFSET_BITS  (OFFSET_BITS),
    .FW           (FW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .desc      (b_desc),
    .pos       (b_pos),
    .fill      (b_fill),
    .ring_flat (b_ring),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench for the byte compare block with context output.
module tb import bdc_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  // queue of four requests, each up to five words, plus the output register
  localparam int DRAIN_CYCLES = 32;
  localparam int RING_DEPTH = 3;

  // One result word as the block should present it.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] off;
    logic [7:0]  vo;
    logic [7:0]  vn;
    logic [31:0] total;
    logic        last;
  } record_t;

  // One row of the directed script: a byte pair, an end word or a register
  // write (index in bo[0], value in bn[0]); typed rows carry their one
  // expected result in place of the predicted one.
  typedef struct packed {
    logic        wr_reg;
    logic [7:0]  bo;
    logic [7:0]  bn;
    logic        eod;
    logic        typed;
    logic [2:0]  kind;
    logic [31:0] off;
    logic [7:0]  vo;
    logic [7:0]  vn;
    logic [31:0] total;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // end word straight after reset: total of zero
    '{1'b0, 8'h00, 8'h00, 1'b1, 1'b1, KIND_TOTAL, 32'd0, 8'h00, 8'h00, 32'd0},
    // one seen byte, then a mismatch: separator, one context byte, difference
    '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    // three trailing context bytes, then the match that closes the hunk
    '{1'b0, 8'hFF, 8'hFF, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'hAA, 8'hAA, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h55, 8'h55, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h12, 8'h12, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    // full ring of pre-context, then two mismatches back to back
    '{1'b0, 8'hFF, 8'h00, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h7F, 8'h80, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    // context used up while the hunk is still open: no new separator
    '{1'b0, 8'h01, 8'h01, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h02, 8'h02, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h03, 8'h03, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h80, 8'h7F, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'h00, 1'b1, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    // patch mode: bare write records only
    '{1'b1, {7'd0, REG_PATCH_MODE}, 8'h01, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'hFF, 1'b0, 1'b1, KIND_PATCH, 32'd0, 8'h00, 8'hFF, 32'd1},
    '{1'b0, 8'h11, 8'h11, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'hFF, 8'hFF, 1'b1, 1'b1, KIND_TOTAL, 32'd0, 8'h00, 8'h00, 32'd1},
    // both modes set: count only wins
    '{1'b1, {7'd0, REG_COUNT_ONLY}, 8'h01, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'hFF, 8'h00, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h5A, 8'h5A, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'h00, 1'b1, 1'b1, KIND_TOTAL, 32'd0, 8'h00, 8'h00, 32'd1},
    // count only by itself
    '{1'b1, {7'd0, REG_PATCH_MODE}, 8'h00, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h01, 8'h02, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'h00, 1'b1, 1'b1, KIND_TOTAL, 32'd0, 8'h00, 8'h00, 32'd1},
    // back to full output: mismatch at offset zero has no pre-context
    '{1'b1, {7'd0, REG_COUNT_ONLY}, 8'h00, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'hC3, 8'h3C, 1'b0, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0},
    '{1'b0, 8'h00, 8'h00, 1'b1, 1'b0, KIND_SEP, 32'd0, 8'h00, 8'h00, 32'd0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;   // byte_old, byte_new
  logic                  in_tlast = 1'b0; // end_of_data
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [79:0]           out_tdata;       // offset, value_old, value_new, mismatch_total
  logic [2:0]            out_tuser;       // record_kind
  logic                  out_tlast;       // last
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic                  cfg_wdata = 1'b0;

  // predictor copy of the block's state and modes
  logic [7:0]  ring_bytes [RING_DEPTH];
  int          ring_slot;
  int          ring_fill;
  logic        hunk_open;
  int          trail_left;
  logic [31:0] byte_pos;
  logic [31:0] diff_count;
  logic        patch_on;
  logic        count_on;

  record_t     pending_records [$];
  int          fails = 0;
  int          words_sent = 0;
  int          cycles = 0;
  int          rx_hold = 0;
  int          rx_next;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  byte_diff_with_context_core dut (.*);

  always #5 clk = ~clk;

  function automatic record_t make_record(logic [2:0] kind, logic [31:0] off,
                                          logic [7:0] vo, logic [7:0] vn);
    return '{kind, off, vo, vn, diff_count, 1'b0};
  endfunction

  function automatic void clear_compare();
    foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
    ring_slot  = 0;
    ring_fill  = 0;
    hunk_open  = 1'b0;
    trail_left = 0;
    byte_pos   = '0;
    diff_count = '0;
  endfunction

  // Advance the predicted state by one word; queue its results when keep is set.
  function automatic void predict_compare(logic [7:0] bo, logic [7:0] bn, logic eod,
                                          bit keep);
    record_t batch [5];
    int      n;
    int      slot;
    logic    quiet;
    logic    full_out;
    n        = 0;
    quiet    = count_on;
    full_out = !quiet && !patch_on;
    if (eod) begin
      batch[0] = make_record(KIND_TOTAL, '0, 8'h00, 8'h00);
      n = 1;
      clear_compare();
    end else begin
      if (bo != bn) begin
        if (diff_count != '1) diff_count = diff_count + 1;
        if (!hunk_open) begin
          if (full_out) begin
            slot = (ring_slot + RING_DEPTH - ring_fill) % RING_DEPTH;
            batch[n] = make_record(KIND_SEP, '0, 8'h00, 8'h00);
            n++;
            // replay the pre-context oldest first
            for (int k = 0; k < ring_fill; k++) begin
              batch[n] = make_record(KIND_CTX, byte_pos - 32'(ring_fill) + 32'(k),
                                     ring_bytes[slot], 8'h00);
              n++;
              slot = (slot + 1) % RING_DEPTH;
            end
          end
          hunk_open = 1'b1;
        end
        if (full_out) begin
          batch[n] = make_record(KIND_DIFF, byte_pos, bo, bn);
          n++;
        end else if (!quiet) begin
          batch[n] = make_record(KIND_PATCH, byte_pos, 8'h00, bn);
          n++;
        end
        trail_left = RING_DEPTH;
      end else begin
        ring_bytes[ring_slot] = bo;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        if (trail_left > 0) begin
          if (full_out) begin
            batch[n] = make_record(KIND_CTX, byte_pos, bo, 8'h00);
            n++;
          end
          trail_left--;
        end else begin
          hunk_open = 1'b0;
        end
      end
      byte_pos = byte_pos + 1;
    end
    if (n > 0) batch[n-1].last = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) pending_records.push_back(batch[k]);
    end
  endfunction

  // Offer one word after a random gap, hold it until taken, then predict it.
  task automatic send_pair(input logic [7:0] bo, input logic [7:0] bn,
                           input logic eod, input bit keep);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bn, bo};
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    predict_compare(bo, bn, eod, keep);
  endtask

  // Write a register once the block has gone quiet.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic val);
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    // drain requests that produce no result word
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (addr == REG_PATCH_MODE) patch_on = val;
    else if (addr == REG_COUNT_ONLY) count_on = val;
  endtask

  task automatic send_mismatch();
    logic [7:0] b;
    b = 8'($urandom);
    send_pair(b, b ^ 8'($urandom_range(1, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_match();
    logic [7:0] b;
    b = 8'($urandom);
    send_pair(b, b, 1'b0, 1'b1);
  endtask

  // Result side: check every accepted word, then drop out_tready at random unless rx_calm is set.
  always @(posedge clk) begin
    rx_next = rx_hold;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_records.size() == 0) begin
        $error("result word with no expectation: record_kind %0d offset %0d",
               out_tuser, out_tdata[31:0]);
        fails++;
      end else begin
        record_t want;
        want = pending_records.pop_front();
        if (out_tuser !== want.kind) begin
          $error("record_kind: expected %0d, got %0d", want.kind, out_tuser);
          fails++;
        end
        if (out_tdata[31:0] !== want.off) begin
          $error("offset: expected %0d, got %0d", want.off, out_tdata[31:0]);
          fails++;
        end
        if (out_tdata[39:32] !== want.vo) begin
          $error("value_old: expected %0h, got %0h", want.vo, out_tdata[39:32]);
          fails++;
        end
        if (out_tdata[47:40] !== want.vn) begin
          $error("value_new: expected %0h, got %0h", want.vn, out_tdata[47:40]);
          fails++;
        end
        if (out_tdata[79:48] !== want.total) begin
          $error("mismatch_total: expected %0d, got %0d", want.total, out_tdata[79:48]);
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fails++;
        end
      end
      rx_next = rx_calm ? 0 : $urandom_range(0, 3);
    end
    if (rx_next > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_next - 1;
    end else begin
      out_tready <= 1'b1;
      rx_hold    <= 0;
    end
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int start;
    clear_compare();
    patch_on = 1'b0;
    count_on = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script: typed rows queue their written-out result.
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].wr_reg) begin
        write_reg(SCRIPT[r].bo[CFG_ADDR_W-1:0], SCRIPT[r].bn[0]);
      end else begin
        send_pair(SCRIPT[r].bo, SCRIPT[r].bn, SCRIPT[r].eod, !SCRIPT[r].typed);
        if (SCRIPT[r].typed)
          pending_records.push_back('{SCRIPT[r].kind, SCRIPT[r].off, SCRIPT[r].vo,
                                      SCRIPT[r].vn, SCRIPT[r].total, 1'b1});
      end
    end

    // Random phases: runs of matches broken by short mismatch bursts, with
    // occasional noise and end words. The first four phases walk every mode.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_PATCH_MODE, 1'b0); write_reg(REG_COUNT_ONLY, 1'b0); end
        1: begin write_reg(REG_PATCH_MODE, 1'b1); write_reg(REG_COUNT_ONLY, 1'b0); end
        2: begin write_reg(REG_PATCH_MODE, 1'b0); write_reg(REG_COUNT_ONLY, 1'b1); end
        3: begin write_reg(REG_PATCH_MODE, 1'b1); write_reg(REG_COUNT_ONLY, 1'b1); end
        default: begin
          write_reg(REG_PATCH_MODE, $urandom_range(0, 3) == 0);
          write_reg(REG_COUNT_ONLY, $urandom_range(0, 3) == 0);
        end
      endcase
      tx_calm = (ph % 3 == 2);
      rx_calm = (ph % 4 == 1);
      start = words_sent;
      while (words_sent - start < 50) begin
        repeat ($urandom_range(0, 6)) send_match();
        repeat ($urandom_range(1, 2)) send_mismatch();
        if ($urandom_range(0, 9) == 0)
          send_pair(8'($urandom), 8'($urandom), 1'b0, 1'b1);
        if ($urandom_range(0, 19) == 0)
          send_pair(8'($urandom), 8'($urandom), 1'b1, 1'b1);
      end
    end

    // Close the last comparison so the total is checked too.
    write_reg(REG_COUNT_ONLY, 1'b0);
    send_pair(8'h00, 8'h00, 1'b1, 1'b1);
    in_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
